>>> rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape core: character
// codes, result status codes and the classified item passed front to back.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Characters that the decoder recognizes.
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_LC_B   = 8'h62;
  localparam logic [7:0] CHAR_LC_N   = 8'h6E;
  localparam logic [7:0] CHAR_LC_R   = 8'h72;
  localparam logic [7:0] CHAR_LC_T   = 8'h74;
  localparam logic [7:0] CHAR_LC_U   = 8'h75;
  localparam logic [7:0] CHAR_DIG_0  = 8'h30;
  localparam logic [7:0] CHAR_DIG_9  = 8'h39;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRAILING = 3'd1,
    ST_SHORT_U  = 3'd2,
    ST_NON_HEX  = 3'd3,
    ST_WIDE     = 3'd4,
    ST_BAD_ESC  = 3'd5
  } status_e;

  // One input byte together with its classification.
  typedef struct packed {
    logic [7:0] raw;       // byte as received
    logic       last;      // final byte of the string
    logic       is_bslash; // byte is a backslash
    logic       is_u;      // byte is the letter u
    logic       esc_ok;    // byte is a known short escape letter
    logic [7:0] esc_byte;  // byte that the short escape stands for
    logic       hex_ok;    // byte is a hex digit of either case
    logic [3:0] hex_val;   // value of that hex digit
  } jsu_item_t;

endpackage

>>> rtl/core/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Input side: accepts raw bytes while the queue has room and classifies each
// one (backslash, escape letter, hex digit) before it is queued.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output jsu_item_t  q_item_o
);

  // Accept whenever the queue can take another item.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the byte.
  always_comb begin
    q_item_o           = '0;
    q_item_o.raw       = in_byte_i;
    q_item_o.last      = in_last_i;
    q_item_o.is_bslash = (in_byte_i == CHAR_BSLASH);
    q_item_o.is_u      = (in_byte_i == CHAR_LC_U);

    // Short escape letters and the bytes they stand for.
    q_item_o.esc_ok = 1'b1;
    unique case (in_byte_i)
      CHAR_LC_B:   q_item_o.esc_byte = BYTE_BS;
      CHAR_LC_N:   q_item_o.esc_byte = BYTE_LF;
      CHAR_LC_R:   q_item_o.esc_byte = BYTE_CR;
      CHAR_LC_T:   q_item_o.esc_byte = BYTE_HT;
      CHAR_QUOTE:  q_item_o.esc_byte = CHAR_QUOTE;
      CHAR_BSLASH: q_item_o.esc_byte = CHAR_BSLASH;
      CHAR_SLASH:  q_item_o.esc_byte = CHAR_SLASH;
      default: begin
        q_item_o.esc_ok   = 1'b0;
        q_item_o.esc_byte = '0;
      end
    endcase

    // Hex digit value; letters map to ten and up.
    if (in_byte_i >= CHAR_DIG_0 && in_byte_i <= CHAR_DIG_9) begin
      q_item_o.hex_ok  = 1'b1;
      q_item_o.hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= CHAR_LC_A && in_byte_i <= CHAR_LC_F) ||
                 (in_byte_i >= CHAR_UC_A && in_byte_i <= CHAR_UC_F)) begin
      q_item_o.hex_ok  = 1'b1;
      q_item_o.hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      q_item_o.hex_ok  = 1'b0;
      q_item_o.hex_val = '0;
    end
  end

endmodule

>>> rtl/core/jsu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of classified items between the front and the back, so that
// each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  jsu_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output jsu_item_t item_o,
  output logic      empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  jsu_item_t       mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Decode side: takes classified items from the queue, runs the escape state
// machine and holds one result in an output register until it is taken.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  jsu_item_t  q_item_i,
  output logic       q_pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output status_e    status_o,
  output logic [2:0] digit_position_o,
  output logic       out_done_o
);

  // Codes two to five count the u digits one to four.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic        disc_q, disc_d;
  logic        res_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        ov_q, ov_d;
  status_e     status_q, status_d;
  logic [2:0]  pos_q, pos_d;
  logic        done_q;
  logic [15:0] acc_next;
  logic        pop;

  // Pop when a result slot is free or is being emptied this cycle.
  assign pop     = !q_empty_i && (!res_valid_q || res_ready_i);
  assign q_pop_o = pop;

  assign acc_next = {acc_q[11:0], q_item_i.hex_val};

  // Next decoder state and result for the item at the queue head.
  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    disc_d   = disc_q;
    byte_d   = '0;
    ov_d     = 1'b0;
    status_d = ST_OK;
    pos_d    = '0;

    if (!disc_q) begin
      unique case (mode_q)
        MODE_ESCAPE: begin
          mode_d = MODE_NORMAL;
          if (q_item_i.esc_ok) begin
            byte_d = q_item_i.esc_byte;
            ov_d   = 1'b1;
          end else if (q_item_i.is_u) begin
            mode_d = MODE_HEX1;
            acc_d  = '0;
            if (q_item_i.last) begin
              status_d = ST_SHORT_U;
            end
          end else begin
            status_d = ST_BAD_ESC;
          end
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!q_item_i.hex_ok) begin
            status_d = ST_NON_HEX;
            pos_d    = mode_q - 3'(MODE_ESCAPE);
            mode_d   = MODE_NORMAL;
          end else begin
            acc_d = acc_next;
            if (mode_q == MODE_HEX4) begin
              mode_d = MODE_NORMAL;
              if (acc_next[15:8] != '0) begin
                status_d = ST_WIDE;
              end else begin
                byte_d = acc_next[7:0];
                ov_d   = 1'b1;
              end
            end else begin
              mode_d = mode_e'(mode_q + 3'd1);
              if (q_item_i.last) begin
                status_d = ST_SHORT_U;
              end
            end
          end
        end
        default: begin
          // Normal mode; the unused codes behave the same way.
          mode_d = MODE_NORMAL;
          if (q_item_i.is_bslash) begin
            mode_d = MODE_ESCAPE;
            if (q_item_i.last) begin
              status_d = ST_TRAILING;
            end
          end else begin
            byte_d = q_item_i.raw;
            ov_d   = 1'b1;
          end
        end
      endcase
    end

    // An error ends decoding; the rest of the string is dropped.
    if (status_d != ST_OK) begin
      mode_d = MODE_NORMAL;
      acc_d  = '0;
      if (!q_item_i.last) begin
        disc_d = 1'b1;
      end
    end
    // The last byte always returns to a clean start.
    if (q_item_i.last) begin
      mode_d = MODE_NORMAL;
      acc_d  = '0;
      disc_d = 1'b0;
    end
  end

  // Decoder state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      acc_q       <= '0;
      disc_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q      <= mode_d;
        acc_q       <= acc_d;
        disc_q      <= disc_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      byte_q   <= byte_d;
      ov_q     <= ov_d;
      status_q <= status_d;
      pos_q    <= pos_d;
      done_q   <= q_item_i.last;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign out_byte_o       = byte_q;
  assign out_valid_o      = ov_q;
  assign status_o         = status_q;
  assign digit_position_o = pos_q;
  assign out_done_o       = done_q;

`ifndef SYNTHESIS
  // While discarding, no escape may be pending.
  a_disc_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
      disc_q |-> (mode_q == MODE_NORMAL && acc_q == '0))
      else $error("discard with escape state pending");

  // The last byte of a string leaves the decoder clean.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pop && q_item_i.last) |=> (!disc_q && mode_q == MODE_NORMAL))
      else $error("state left after last byte");

  // An error result never carries a decoded byte.
  a_err_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && status_q != ST_OK) |-> !ov_q)
      else $error("error result with decoded byte");

  // A digit position comes only with a non-hex status.
  a_pos_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_q |-> ((pos_q != '0) == (status_q == ST_NON_HEX)))
      else $error("digit position does not match status");
`endif

endmodule

>>> rtl/core/json_string_unescape_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Byte-serial JSON string unescape: classifies bytes, queues them and decodes
// escapes, giving one result for every input byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one raw byte per item with
//   in_last_i marking the final byte of a string. Output channel
//   res_valid_o/res_ready_i carries exactly one result per input byte:
//   the decoded byte with its out_valid_o flag, a status code, the position
//   of a bad u digit and out_done_o, which repeats the byte's last flag.
//   A result is registered first in the queue and then in the output register
//   after its byte is accepted, and is taken from the output register.
//   Throughput is one byte per cycle while the receiver takes every result,
//   set by the decode step in the back end.
//   When the receiver stalls, the result holds in the output register and
//   the queue (FifoDepth items) keeps taking bytes until it is full; then
//   in_ready_o drops. After the first error of a string, the remaining bytes
//   up to the last one give empty results.
//   Reset empties the queue and the output register and returns the decoder
//   to normal mode with no escape pending.
// ----------------------------------------------------------------------------
module json_string_unescape_core import jsu_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic [2:0] status_o,
  output logic [2:0] digit_position_o,
  output logic       out_done_o
);

  jsu_item_t push_item, head_item;
  logic      push, pop, full, empty;
  status_e   status;

  // Front end: accept and classify.
  jsu_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_item_o   (push_item)
  );

  // Queue between the two sides.
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  // Back end: decode and hold the result.
  jsu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (empty),
    .q_item_i         (head_item),
    .q_pop_o          (pop),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .out_byte_o       (out_byte_o),
    .out_valid_o      (out_valid_o),
    .status_o         (status),
    .digit_position_o (digit_position_o),
    .out_done_o       (out_done_o)
  );

  assign status_o = 3'(status);

endmodule

>>> dv/json_string_unescape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_checker
// Scoreboard for the JSON string unescape core. It watches both channels,
// runs its own byte-serial decoder on every accepted input item and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module json_string_unescape_checker import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_valid_i,
  input  logic [2:0] status_i,
  input  logic [2:0] digit_position_i,
  input  logic       out_done_i,
  output int         outstanding_o,
  output int         fail_count_o
);

  // Decoder phase: plain text, after a backslash, or waiting for u digit 1..4.
  typedef enum logic [2:0] {
    DM_IDLE = 3'd0,
    DM_ESC  = 3'd1,
    DM_HEX1 = 3'd2,
    DM_HEX2 = 3'd3,
    DM_HEX3 = 3'd4,
    DM_HEX4 = 3'd5
  } esc_mode_e;

  // One decoded result as the core should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_e    status;
    logic [2:0] pos;
    logic       done;
  } unesc_result_t;

  esc_mode_e     esc_mode = DM_IDLE;
  logic [15:0]   hex_acc  = '0;
  logic          skipping = 1'b0;
  unesc_result_t decoded_q[$];
  int            mismatches = 0;
  int            checked    = 0;

  assign fail_count_o = mismatches;

  // Value of a hex digit of either case in nib; returns 1 for a hex digit, 0 for any other byte.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      nib = 4'(c - CHAR_DIG_0);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      nib = 4'(c - CHAR_LC_A + 8'd10);
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      nib = 4'(c - CHAR_UC_A + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the decoder by one input item and returns the result it gives.
  task automatic decode_byte(input logic [7:0] c, input logic last, output unesc_result_t r);
    logic [3:0] nib;
    r        = '0;
    r.status = ST_OK;
    r.done   = last;
    if (skipping) begin
      // The rest of a failed string gives empty results.
    end else if (esc_mode == DM_ESC) begin
      esc_mode = DM_IDLE;
      r.valid  = 1'b1;
      case (c)
        CHAR_LC_B: r.data = BYTE_BS;
        CHAR_LC_N: r.data = BYTE_LF;
        CHAR_LC_R: r.data = BYTE_CR;
        CHAR_LC_T: r.data = BYTE_HT;
        CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: r.data = c;
        CHAR_LC_U: begin
          r.valid  = 1'b0;
          esc_mode = DM_HEX1;
          hex_acc  = '0;
          if (last) r.status = ST_SHORT_U;
        end
        default: begin
          r.valid  = 1'b0;
          r.status = ST_BAD_ESC;
        end
      endcase
    end else if (esc_mode >= DM_HEX1 && esc_mode <= DM_HEX4) begin
      if (!hex_nibble(c, nib)) begin
        r.status = ST_NON_HEX;
        r.pos    = 3'(esc_mode - DM_HEX1 + 3'd1);
        esc_mode = DM_IDLE;
      end else begin
        hex_acc = {hex_acc[11:0], nib};
        if (esc_mode == DM_HEX4) begin
          esc_mode = DM_IDLE;
          // Only code points that fit in one byte are emitted.
          if (hex_acc > 16'h00FF) begin
            r.status = ST_WIDE;
          end else begin
            r.data  = hex_acc[7:0];
            r.valid = 1'b1;
          end
        end else begin
          esc_mode = esc_mode_e'(esc_mode + 3'd1);
          if (last) r.status = ST_SHORT_U;
        end
      end
    end else begin
      esc_mode = DM_IDLE;
      if (c == CHAR_BSLASH) begin
        esc_mode = DM_ESC;
        if (last) r.status = ST_TRAILING;
      end else begin
        r.data  = c;
        r.valid = 1'b1;
      end
    end

    // An error drops any pending escape and, mid-string, skips the rest.
    if (r.status != ST_OK) begin
      esc_mode = DM_IDLE;
      hex_acc  = '0;
      if (!last) skipping = 1'b1;
    end
    if (last) begin
      esc_mode = DM_IDLE;
      hex_acc  = '0;
      skipping = 1'b0;
    end
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $time, checked, what, got,
             want);
  endtask

  // Predict on every accepted input item, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    unesc_result_t want;
    if (!rst_ni) begin
      esc_mode = DM_IDLE;
      hex_acc  = '0;
      skipping = 1'b0;
      decoded_q.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_byte_i, in_last_i, want);
        decoded_q.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        checked++;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing pending, out_byte", int'(out_byte_i), 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch("out_byte", int'(out_byte_i), int'(want.data));
          end
          if (out_valid_i !== want.valid) begin
            report_mismatch("out_valid", int'(out_valid_i), int'(want.valid));
          end
          if (status_i !== want.status) begin
            report_mismatch("status", int'(status_i), int'(want.status));
          end
          if (digit_position_i !== want.pos) begin
            report_mismatch("digit_position", int'(digit_position_i), int'(want.pos));
          end
          if (out_done_i !== want.done) begin
            report_mismatch("out_done", int'(out_done_i), int'(want.done));
          end
        end
      end
      outstanding_o <= decoded_q.size();
    end
  end

endmodule

>>> dv/json_string_unescape_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_core_tb
// Drives escaped strings into the unescape core: a directed set covering
// every escape letter, the byte extremes and each error status, then random
// strings built mostly from plain bytes and well-formed escapes with some noise and cut-off
// endings. Both channels stall at random; a checker scores every result.
// ----------------------------------------------------------------------------
module json_string_unescape_core_tb import jsu_pkg::*; ();

  localparam int RandomItems = 1150;
  localparam int LongHold    = 300;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte     = '0;
  logic       in_last     = 1'b0;
  logic       res_valid;
  logic       res_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] status;
  logic [2:0] digit_position;
  logic       out_done;
  int         outstanding;
  int         fail_count;

  int         items_sent   = 0;
  int         strings_sent = 0;
  int         hold_asked   = 0;
  int         hold_served  = 0;
  bit         steady       = 1'b0;
  logic [7:0] text_q[$];

  json_string_unescape_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .in_byte_i        (in_byte),
    .in_last_i        (in_last),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .out_byte_o       (out_byte),
    .out_valid_o      (out_valid),
    .status_o         (status),
    .digit_position_o (digit_position),
    .out_done_o       (out_done)
  );

  json_string_unescape_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_byte_i        (in_byte),
    .in_last_i        (in_last),
    .res_valid_i      (res_valid),
    .res_ready_i      (res_ready),
    .out_byte_i       (out_byte),
    .out_valid_i      (out_valid),
    .status_i         (status),
    .digit_position_i (digit_position),
    .out_done_i       (out_done),
    .outstanding_o    (outstanding),
    .fail_count_o     (fail_count)
  );

  // Clock and a single reset at the start.
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the core hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) || (c >= CHAR_LC_A && c <= CHAR_LC_F) ||
           (c >= CHAR_UC_A && c <= CHAR_UC_F);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c inside {CHAR_LC_B, CHAR_LC_N, CHAR_LC_R, CHAR_LC_T, CHAR_QUOTE, CHAR_BSLASH,
                     CHAR_SLASH, CHAR_LC_U};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CHAR_DIG_0 + 8'(nib);
    return (upper ? CHAR_UC_A : CHAR_LC_A) + 8'(nib - 4'd10);
  endfunction

  function automatic logic [7:0] short_escape_letter(input int sel);
    case (sel)
      0:       return CHAR_LC_B;
      1:       return CHAR_LC_N;
      2:       return CHAR_LC_R;
      3:       return CHAR_LC_T;
      4:       return CHAR_QUOTE;
      5:       return CHAR_BSLASH;
      default: return CHAR_SLASH;
    endcase
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Backslash, u and four digits of the given value in random letter case.
  task automatic queue_u_escape(input logic [15:0] value);
    text_q.push_back(CHAR_BSLASH);
    text_q.push_back(CHAR_LC_U);
    for (int i = 3; i >= 0; i--) begin
      text_q.push_back(hex_char(value[i*4 +: 4], 1'($urandom_range(0, 1))));
    end
  endtask

  // One random piece of a string; most pieces are well formed.
  task automatic queue_random_token();
    int         k;
    logic [7:0] b;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_BSLASH);
      text_q.push_back(b);
    end else if (k < 62) begin
      text_q.push_back(CHAR_BSLASH);
      text_q.push_back(short_escape_letter($urandom_range(0, 6)));
    end else if (k < 78) begin
      queue_u_escape(16'($urandom_range(0, 255)));
    end else if (k < 83) begin
      queue_u_escape(16'($urandom_range(256, 65535)));
    end else if (k < 87) begin
      // Unknown escape letter.
      text_q.push_back(CHAR_BSLASH);
      do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
      text_q.push_back(b);
    end else if (k < 91) begin
      // Bad digit somewhere in a u escape.
      text_q.push_back(CHAR_BSLASH);
      text_q.push_back(CHAR_LC_U);
      repeat ($urandom_range(0, 3)) begin
        text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
      text_q.push_back(b);
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Offers one item and holds it until accepted, then maybe idles.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    in_valid <= 1'b1;
    in_byte  <= value;
    in_last  <= is_last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Sends the queued string with the last flag on its final byte.
  task automatic send_string();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        res_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        res_ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int random_start;
    int cut;
    do @(posedge clk); while (!rst_n);

    // Every short escape between the two byte extremes.
    text_q.push_back(8'h00);
    queue_text("\\b\\n\\r\\t\\\"\\\\\\/");
    text_q.push_back(8'hFF);
    send_string();
    // Largest u value that still fits in a byte, mixed case.
    queue_text("\\u00Ff");
    send_string();
    // Backslash as the final byte.
    queue_text("\\");
    send_string();
    // String ends after the first u digit.
    queue_text("\\u7");
    send_string();
    // Bad second u digit, then the rest of the string is skipped.
    queue_text("\\u0gx");
    send_string();
    // Wide character on the final byte.
    queue_text("\\u1000");
    send_string();
    // Unknown escape letter, then a skipped backslash.
    queue_text("\\q\\");
    send_string();
    pause_until_drained();

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      if (strings_sent == 30) hold_asked++;
      if (strings_sent == 60) pause_until_drained();
      steady = (strings_sent >= 80 && strings_sent < 95);
      repeat ($urandom_range(1, 6)) queue_random_token();
      // Some strings are cut short, often in the middle of an escape.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
      send_string();
    end
    steady = 1'b0;

    pause_until_drained();
    repeat (16) @(posedge clk);
    $display("Sent %0d bytes in %0d strings: plain bytes, short and u escapes,", items_sent,
             strings_sent);
    $display("cut-off strings and every error status, with stalls on both channels.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_fifo.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_core.sv
dv/json_string_unescape_checker.sv
dv/json_string_unescape_core_tb.sv
